@@ rtl/can_motor_command_encoder_tracker_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the motor command encoder tracker
// Each macro expects aclk and aresetn in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef CAN_MOTOR_COMMAND_ENCODER_TRACKER_MACROS_SVH
`define CAN_MOTOR_COMMAND_ENCODER_TRACKER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CMET_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CMET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cmet_pkg.sv @@
// ----------------------------------------------------------------------------
// cmet_pkg
// Shared types, codes and frame layout function for the motor command
// encoder tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package cmet_pkg;

    // Single-turn encoder resolution
    localparam int EncBits = 16;
    localparam logic [31:0] EncHalf = 32'(1) << (EncBits - 1);

    // Result queue between front and back
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    // Operation codes
    typedef enum logic [3:0] {
        OpSpeed    = 4'd0,
        OpStop     = 4'd1,
        OpStopHold = 4'd2,
        OpEnable   = 4'd3,
        OpDisable  = 4'd4,
        OpReadEnc  = 4'd5,
        OpEncSamp  = 4'd6,
        OpZeroOfs  = 4'd7,
        OpSetPos   = 4'd8
    } op_t;

    // Configuration register indexes
    localparam logic [2:0] RegAxis   = 3'd0;
    localparam logic [2:0] RegExtId  = 3'd1;
    localparam logic [2:0] RegStdId  = 3'd2;
    localparam logic [2:0] RegMaxSpd = 3'd3;
    localparam logic [2:0] RegPosTol = 3'd4;

    // Frame bytes
    localparam logic [7:0] AxisLead   = 8'h23;
    localparam logic [7:0] AxisMid    = 8'h20;
    localparam logic [7:0] OpcSpeed   = 8'hA2;
    localparam logic [7:0] OpcStop    = 8'h81;
    localparam logic [7:0] OpcEnable  = 8'h88;
    localparam logic [7:0] OpcDisable = 8'h80;
    localparam logic [7:0] OpcReadEnc = 8'h9C;
    localparam logic [7:0] SubNone    = 8'h00;
    localparam logic [7:0] SubEnable  = 8'h0D;
    localparam logic [7:0] SubDisable = 8'h0C;

    // Configuration register set
    typedef struct packed {
        logic [7:0]  axis;
        logic [28:0] ext_id;
        logic [10:0] std_id;
        logic [30:0] max_speed;
        logic [30:0] pos_tol;
    } cfg_t;

    // One queued transaction: the main frame plus the state after the item
    typedef struct packed {
        logic        has_frame;
        logic        two;        // read-encoder frame goes out first
        logic [7:0]  opcode;
        logic [7:0]  sub;
        logic [31:0] data;
        logic [31:0] position;
        logic [31:0] speed;
    } entry_t;

    // Axis layout is big-endian after the header; opcode layout little-endian
    function automatic logic [63:0] build_frame(input logic [7:0] axis,
                                                input logic [7:0] opcode,
                                                input logic [7:0] sub,
                                                input logic [31:0] data);
        logic [63:0] f;
        if (axis != 8'd0) begin
            f = {data[7:0], data[15:8], data[23:16], data[31:24],
                 axis, AxisMid, sub, AxisLead};
        end else begin
            f = {data, 24'd0, opcode};
        end
        return f;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cmet_front.sv @@
// ----------------------------------------------------------------------------
// cmet_front
// Accepts operations, decodes them, updates the encoder tracking and speed
// state and pushes one entry per transaction into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cmet_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire cmet_pkg::cfg_t  cfg,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [3:0]      s_operation,
    input  wire logic [31:0]     s_value,
    input  wire logic [15:0]     s_raw_count,
    output logic                 q_push,
    output cmet_pkg::entry_t     q_entry,
    input  wire logic            q_full
);
    import cmet_pkg::*;

    // u_reg     : previous unwrapped count plus half a turn
    // base_reg  : u_reg minus the captured zero offset
    // Both move by the same step, so the tracked position after a sample
    // is one add away.
    logic [31:0] u_reg, u_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] track_reg, track_next;
    logic [31:0] speed_reg, speed_next;

    logic               accept;
    logic [31:0]        raw_ext;
    logic [EncBits-1:0] d_low;
    logic [31:0]        step;
    logic signed [33:0] diff;
    logic signed [33:0] tol_s;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    // Wrapped step, sign-extended from the encoder width
    assign raw_ext = 32'(s_raw_count);
    assign d_low   = raw_ext[EncBits-1:0] - u_reg[EncBits-1:0];
    assign step    = {{(32-EncBits){d_low[EncBits-1]}}, d_low};

    // Exact target minus position for the set-position dead band
    assign diff  = $signed({{2{s_value[31]}}, s_value})
                 - $signed({{2{track_reg[31]}}, track_reg});
    assign tol_s = $signed({3'b000, cfg.pos_tol});

    // Decode
    always_comb begin
        u_next     = u_reg;
        base_next  = base_reg;
        track_next = track_reg;
        speed_next = speed_reg;

        q_entry           = '0;
        q_entry.has_frame = 1'b1;

        case (op_t'(s_operation))
            OpSpeed: begin
                q_entry.opcode = OpcSpeed;
                q_entry.data   = s_value;
            end
            OpStop: begin
                speed_next     = 32'd0;
                q_entry.opcode = OpcStop;
            end
            OpStopHold: begin
                speed_next     = 32'd0;
                q_entry.opcode = OpcSpeed;
            end
            OpEnable: begin
                q_entry.opcode = OpcEnable;
                q_entry.sub    = SubEnable;
            end
            OpDisable: begin
                q_entry.opcode = OpcDisable;
                q_entry.sub    = SubDisable;
            end
            OpReadEnc: begin
                q_entry.opcode = OpcReadEnc;
                q_entry.sub    = SubDisable;
            end
            OpEncSamp: begin
                u_next            = u_reg + step;
                base_next         = base_reg + step;
                track_next        = base_reg + step;
                q_entry.has_frame = 1'b0;
            end
            OpZeroOfs: begin
                // offset becomes the shown position; rebase the next sample
                base_next         = u_reg - track_reg;
                q_entry.has_frame = 1'b0;
            end
            OpSetPos: begin
                if (cfg.ext_id != 29'd0) begin
                    q_entry.has_frame = 1'b0;
                end else begin
                    q_entry.two = 1'b1;
                    if (diff < -tol_s) begin
                        speed_next     = 32'd0 - {1'b0, cfg.max_speed};
                        q_entry.opcode = OpcSpeed;
                        q_entry.data   = speed_next;
                    end else if (diff > tol_s) begin
                        speed_next     = {1'b0, cfg.max_speed};
                        q_entry.opcode = OpcSpeed;
                        q_entry.data   = speed_next;
                    end else begin
                        speed_next     = 32'd0;
                        q_entry.opcode = OpcStop;
                    end
                end
            end
            default: begin
                q_entry.has_frame = 1'b0;
            end
        endcase

        q_entry.position = track_next;
        q_entry.speed    = speed_next;
    end

    // Tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_reg     <= EncHalf;
            base_reg  <= EncHalf;
            track_reg <= 32'd0;
            speed_reg <= 32'd0;
        end else if (accept) begin
            u_reg     <= u_next;
            base_reg  <= base_next;
            track_reg <= track_next;
            speed_reg <= speed_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/cmet_queue.sv @@
// ----------------------------------------------------------------------------
// cmet_queue
// Short FIFO of decoded entries between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cmet_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire cmet_pkg::entry_t push_entry,
    output logic                  full,
    input  wire logic             pop,
    output cmet_pkg::entry_t      pop_entry,
    output logic                  empty
);
    import cmet_pkg::*;

    entry_t           mem [QDepth];
    logic [QAw-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAw-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAw:0]     count_reg, count_next;

    assign full      = (count_reg == (QAw+1)'(QDepth));
    assign empty     = (count_reg == '0);
    assign pop_entry = mem[rd_ptr_reg];

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

@@ rtl/cmet_back.sv @@
// ----------------------------------------------------------------------------
// cmet_back
// Takes entries from the queue, builds the CAN frames and drives the result
// output register; a set-position entry with a standard id expands into two results.
// ----------------------------------------------------------------------------
`default_nettype none

module cmet_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cmet_pkg::cfg_t   cfg,
    input  wire cmet_pkg::entry_t q_entry,
    input  wire logic             q_empty,
    output logic                  q_pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_frame_valid,
    output logic                  m_frame_extended,
    output logic [28:0]           m_frame_id,
    output logic [63:0]           m_frame_data,
    output logic signed [31:0]    m_position,
    output logic signed [31:0]    m_speed,
    output logic                  m_last
);
    import cmet_pkg::*;

    logic        valid_reg, valid_next;
    logic        pend_reg, pend_next;
    entry_t      held_reg;
    logic        fv_reg, ext_reg, last_reg;
    logic [28:0] id_reg;
    logic [63:0] data_reg;
    logic [31:0] pos_reg, spd_reg;

    logic        load_ok;
    logic        load;
    entry_t      src;
    logic        src_fv;
    logic        src_last;
    logic [7:0]  src_opc;
    logic [7:0]  src_sub;
    logic [31:0] src_data;

    assign load_ok = !valid_reg || m_ready;
    assign q_pop   = load_ok && !pend_reg && !q_empty;
    assign load    = load_ok && (pend_reg || !q_empty);

    // Pick what goes into the output register next
    always_comb begin
        src      = pend_reg ? held_reg : q_entry;
        src_fv   = src.has_frame;
        src_last = 1'b1;
        src_opc  = src.opcode;
        src_sub  = src.sub;
        src_data = src.data;
        pend_next = pend_reg;
        if (pend_reg) begin
            if (load_ok) begin
                pend_next = 1'b0;
            end
        end else if (q_pop && q_entry.two) begin
            // read-encoder frame leads; main frame follows
            pend_next = 1'b1;
            src_last  = 1'b0;
            src_opc   = OpcReadEnc;
            src_sub   = SubDisable;
            src_data  = 32'd0;
        end
        valid_next = load_ok ? load : valid_reg;
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            held_reg <= q_entry;
        end
        if (load) begin
            fv_reg   <= src_fv;
            ext_reg  <= src_fv && (cfg.ext_id != 29'd0);
            id_reg   <= !src_fv ? 29'd0
                      : (cfg.ext_id != 29'd0) ? cfg.ext_id : 29'(cfg.std_id);
            data_reg <= src_fv ? build_frame(cfg.axis, src_opc, src_sub, src_data)
                               : 64'd0;
            pos_reg  <= src.position;
            spd_reg  <= src.speed;
            last_reg <= src_last;
        end
    end

    assign m_valid          = valid_reg;
    assign m_frame_valid    = fv_reg;
    assign m_frame_extended = ext_reg;
    assign m_frame_id       = id_reg;
    assign m_frame_data     = data_reg;
    assign m_position       = pos_reg;
    assign m_speed          = spd_reg;
    assign m_last           = last_reg;

endmodule

`default_nettype wire

@@ rtl/can_motor_command_encoder_tracker.sv @@
// ----------------------------------------------------------------------------
// can_motor_command_encoder_tracker
// CAN motor command framer with multi-turn encoder position tracking.
// ----------------------------------------------------------------------------
// One operation is accepted per cycle while the four-entry result queue has
// room. The front decodes it and updates position and speed in the cycle of
// acceptance; results pass through the queue and the output register. While
// m_ready is high the output register delivers one result per cycle: one per
// single-frame or no-frame operation, two for std-id set-position. Position
// and speed on every result show the state after the whole operation. The
// user writes configuration through cfg_we, cfg_index and cfg_wdata only
// while no transaction is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "can_motor_command_encoder_tracker_macros.svh"

module can_motor_command_encoder_tracker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [30:0]        cfg_wdata,
    // operations
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [3:0]         s_operation,
    input  wire logic signed [31:0] s_value,
    input  wire logic [15:0]        s_raw_count,
    // results
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_frame_valid,
    output logic                    m_frame_extended,
    output logic [28:0]             m_frame_id,
    output logic [63:0]             m_frame_data,
    output logic signed [31:0]      m_position,
    output logic signed [31:0]      m_speed,
    output logic                    m_last
);
    import cmet_pkg::*;

    cfg_t   cfg_reg;
    logic   q_push, q_full, q_pop, q_empty;
    entry_t push_entry, pop_entry;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.axis      <= 8'd0;
            cfg_reg.ext_id    <= 29'd0;
            cfg_reg.std_id    <= 11'd0;
            cfg_reg.max_speed <= 31'd1000;
            cfg_reg.pos_tol   <= 31'd10;
        end else if (cfg_we) begin
            case (cfg_index)
                RegAxis:   cfg_reg.axis      <= cfg_wdata[7:0];
                RegExtId:  cfg_reg.ext_id    <= cfg_wdata[28:0];
                RegStdId:  cfg_reg.std_id    <= cfg_wdata[10:0];
                RegMaxSpd: cfg_reg.max_speed <= cfg_wdata;
                RegPosTol: cfg_reg.pos_tol   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    cmet_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_value     (s_value),
        .s_raw_count (s_raw_count),
        .q_push      (q_push),
        .q_entry     (push_entry),
        .q_full      (q_full)
    );

    cmet_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    cmet_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .q_entry          (pop_entry),
        .q_empty          (q_empty),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_valid    (m_frame_valid),
        .m_frame_extended (m_frame_extended),
        .m_frame_id       (m_frame_id),
        .m_frame_data     (m_frame_data),
        .m_position       (m_position),
        .m_speed          (m_speed),
        .m_last           (m_last)
    );

    // Checks
    `CMET_ASSERT_SAME(a_noframe_zero, m_valid && !m_frame_valid, !m_frame_extended && m_frame_id == 29'd0 && m_frame_data == 64'd0, "no-frame result carries frame fields")
    `CMET_ASSERT_SAME(a_first_is_frame, m_valid && !m_last, m_frame_valid, "non-final result without a frame")
    `CMET_ASSERT_NEXT(a_second_follows, m_valid && !m_last && m_ready, m_valid && m_last, "second set-position frame not delivered next")

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CAN motor command framer and encoder tracker.
// Directed tests cover both frame layouts, encoder wrap cases, the
// set-position dead band and extended-id mode. A random phase follows, with
// several register settings and idle patterns, plus a long result-side stall
// that fills the block. Each m_ transaction is checked in order against a
// local prediction of the frame and of the tracked position and speed.
// ----------------------------------------------------------------------------
module tb_top;
    import cmet_pkg::*;

    localparam int HalfPeriod   = 10;
    localparam int ResetCycles  = 5;
    localparam int StallLimit   = 5000;
    localparam int SettleCycles = 8;
    localparam int HoldCycles   = 300;
    localparam int MaxReports   = 10;
    localparam int BlockItems   = 150;
    localparam int BurstItems   = 24;

    // Operation codes and register indexes with no function
    localparam logic [3:0] OpFirstUnused  = 4'd9;
    localparam logic [3:0] OpLastUnused   = 4'd15;
    localparam logic [2:0] RegFirstUnused = 3'd5;
    localparam logic [2:0] RegLastUnused  = 3'd7;

    typedef struct packed {
        logic        frame_valid;
        logic        frame_extended;
        logic [28:0] frame_id;
        logic [63:0] frame_data;
        logic [31:0] position;
        logic [31:0] speed;
        logic        last;
    } motor_result_t;

    // DUT connections
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [2:0]  cfg_index   = RegAxis;
    logic [30:0] cfg_wdata   = '0;
    logic        s_valid     = 1'b0;
    logic [3:0]  s_operation = OpSpeed;
    logic [31:0] s_value     = '0;
    logic [15:0] s_raw_count = '0;
    logic        m_ready     = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_frame_valid;
    logic        m_frame_extended;
    logic [28:0] m_frame_id;
    logic [63:0] m_frame_data;
    logic [31:0] m_position;
    logic [31:0] m_speed;
    logic        m_last;

    // Predicted register values
    logic [7:0]  cur_axis;
    logic [28:0] cur_ext_id;
    logic [10:0] cur_std_id;
    logic [30:0] cur_max_speed;
    logic [30:0] cur_pos_tol;

    // Predicted tracker state
    logic [31:0] enc_prev;
    logic [31:0] enc_zero;
    logic [31:0] track_pos;
    logic [31:0] track_speed;

    motor_result_t due_results[$];

    int          mismatches    = 0;
    int          quiet_cycles  = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_requests = 0;
    int          holds_served  = 0;
    int          hold_left     = 0;
    logic [15:0] enc_raw       = '0;

    can_motor_command_encoder_tracker dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_value          (s_value),
        .s_raw_count      (s_raw_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_valid    (m_frame_valid),
        .m_frame_extended (m_frame_extended),
        .m_frame_id       (m_frame_id),
        .m_frame_data     (m_frame_data),
        .m_position       (m_position),
        .m_speed          (m_speed),
        .m_last           (m_last)
    );

    initial begin
        forever #HalfPeriod aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic void init_model();
        cur_axis      = '0;
        cur_ext_id    = '0;
        cur_std_id    = '0;
        cur_max_speed = 31'd1000;
        cur_pos_tol   = 31'd10;
        enc_prev      = '0;
        enc_zero      = '0;
        track_pos     = '0;
        track_speed   = '0;
    endfunction

    // Payload bytes in the layout picked by the axis register
    function automatic logic [63:0] frame_bytes(input logic [7:0] opc,
                                                input logic [7:0] sub,
                                                input logic [31:0] data);
        logic [63:0] f;
        f = '0;
        if (cur_axis != 8'd0) begin
            // axis-addressed header, data most significant byte first
            f[7:0]   = AxisLead;
            f[15:8]  = sub;
            f[23:16] = AxisMid;
            f[31:24] = cur_axis;
            f[39:32] = data[31:24];
            f[47:40] = data[23:16];
            f[55:48] = data[15:8];
            f[63:56] = data[7:0];
        end else begin
            // opcode-led, data little-endian in bytes 4..7
            f[7:0]   = opc;
            f[63:32] = data;
        end
        return f;
    endfunction

    function automatic void predict_operation(input logic [3:0] op,
                                              input logic [31:0] value,
                                              input logic [15:0] raw);
        logic [63:0]   frames [2];
        logic          framed;
        int            n;
        logic [31:0]   diff;
        logic [31:0]   step;
        longint        target;
        longint        here;
        longint        band;
        motor_result_t r;

        framed    = 1'b1;
        n         = 1;
        frames[0] = '0;
        frames[1] = '0;
        case (op)
            OpSpeed: begin
                frames[0] = frame_bytes(OpcSpeed, SubNone, value);
            end
            OpStop: begin
                track_speed = '0;
                frames[0]   = frame_bytes(OpcStop, SubNone, '0);
            end
            OpStopHold: begin
                track_speed = '0;
                frames[0]   = frame_bytes(OpcSpeed, SubNone, '0);
            end
            OpEnable: begin
                frames[0] = frame_bytes(OpcEnable, SubEnable, '0);
            end
            OpDisable: begin
                frames[0] = frame_bytes(OpcDisable, SubDisable, '0);
            end
            OpReadEnc: begin
                // read-encoder shares the disable sub-index
                frames[0] = frame_bytes(OpcReadEnc, SubDisable, '0);
            end
            OpEncSamp: begin
                // step is the wrapped difference, sign-extended from EncBits
                framed    = 1'b0;
                diff      = 32'(raw[EncBits-1:0]) - EncHalf - enc_prev;
                step      = {{(32-EncBits){diff[EncBits-1]}}, diff[EncBits-1:0]};
                enc_prev  = enc_prev + step;
                track_pos = enc_prev + EncHalf - enc_zero;
            end
            OpZeroOfs: begin
                framed   = 1'b0;
                enc_zero = track_pos;
            end
            OpSetPos: begin
                if (cur_ext_id != '0) begin
                    framed = 1'b0;
                end else begin
                    // exact comparison against the dead band, no wrap
                    n         = 2;
                    target    = longint'($signed(value));
                    here      = longint'($signed(track_pos));
                    band      = longint'(cur_pos_tol);
                    frames[0] = frame_bytes(OpcReadEnc, SubDisable, '0);
                    if (target < here - band) begin
                        track_speed = 32'd0 - 32'(cur_max_speed);
                        frames[1]   = frame_bytes(OpcSpeed, SubNone, track_speed);
                    end else if (target > here + band) begin
                        track_speed = 32'(cur_max_speed);
                        frames[1]   = frame_bytes(OpcSpeed, SubNone, track_speed);
                    end else begin
                        track_speed = '0;
                        frames[1]   = frame_bytes(OpcStop, SubNone, '0);
                    end
                end
            end
            default: begin
                framed = 1'b0;
            end
        endcase

        // position and speed show the state after the whole transaction
        for (int k = 0; k < n; k++) begin
            r.frame_valid    = framed;
            r.frame_extended = framed && (cur_ext_id != '0);
            r.frame_id       = !framed ? '0 :
                               (cur_ext_id != '0) ? cur_ext_id : 29'(cur_std_id);
            r.frame_data     = framed ? frames[k] : '0;
            r.position       = track_pos;
            r.speed          = track_speed;
            r.last           = (k == n - 1);
            due_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    function automatic void report_mismatch(input string what,
                                            input motor_result_t want,
                                            input motor_result_t got);
        mismatches++;
        if (mismatches <= MaxReports) begin
            $display("%0t %s", $realtime, what);
            $display("  exp fv=%0b ext=%0b id=%h data=%h pos=%0d spd=%0d last=%0b",
                     want.frame_valid, want.frame_extended, want.frame_id,
                     want.frame_data, $signed(want.position), $signed(want.speed),
                     want.last);
            $display("  got fv=%0b ext=%0b id=%h data=%h pos=%0d spd=%0d last=%0b",
                     got.frame_valid, got.frame_extended, got.frame_id,
                     got.frame_data, $signed(got.position), $signed(got.speed),
                     got.last);
        end
    endfunction

    always @(posedge aclk) begin : check_results
        motor_result_t got;
        motor_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_frame_valid, m_frame_extended, m_frame_id, m_frame_data,
                   m_position, m_speed, m_last};
            if (due_results.size() == 0) begin
                report_mismatch("result transaction with nothing due", '0, got);
            end else begin
                want = due_results.pop_front();
                if (got.frame_valid !== want.frame_valid ||
                    got.frame_extended !== want.frame_extended ||
                    got.frame_id !== want.frame_id ||
                    got.frame_data !== want.frame_data ||
                    got.position !== want.position ||
                    got.speed !== want.speed ||
                    got.last !== want.last) begin
                    report_mismatch("result transaction mismatch", want, got);
                end
            end
        end
    end

    // Result-side ready: random idling, or a long counted hold when requested
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            m_ready      <= 1'b0;
            hold_left    <= HoldCycles;
            holds_served <= holds_served + 1;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= StallLimit) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Write every register; unused upper bits of the axis, ext-id and std-id write data hold noise
    task automatic write_config(input logic [7:0] axis_v, input logic [28:0] ext_v,
                                input logic [10:0] std_v, input logic [30:0] max_v,
                                input logic [30:0] tol_v);
        logic [30:0] noise;
        noise = 31'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= RegAxis;
        cfg_wdata <= {noise[30:8], axis_v};
        @(posedge aclk);
        cfg_index <= RegExtId;
        cfg_wdata <= {noise[30:29], ext_v};
        @(posedge aclk);
        cfg_index <= RegStdId;
        cfg_wdata <= {noise[30:11], std_v};
        @(posedge aclk);
        cfg_index <= RegMaxSpd;
        cfg_wdata <= max_v;
        @(posedge aclk);
        cfg_index <= RegPosTol;
        cfg_wdata <= tol_v;
        @(posedge aclk);
        // index with no register: must be dropped
        cfg_index <= 3'($urandom_range(RegLastUnused, RegFirstUnused));
        cfg_wdata <= noise;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_axis      = axis_v;
        cur_ext_id    = ext_v;
        cur_std_id    = std_v;
        cur_max_speed = max_v;
        cur_pos_tol   = tol_v;
    endtask

    // Offer one operation and wait for its transaction
    task automatic send_op(input logic [3:0] op, input logic [31:0] value,
                           input logic [15:0] raw);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_value     <= value;
        s_raw_count <= raw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_operation(op, value, raw);
    endtask

    // Stop offering and wait until every due result has been seen
    task automatic drain_results();
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    // Mostly smooth rotation and targets near the dead band edges
    task automatic send_random_item();
        int          pick;
        logic [3:0]  op;
        logic [31:0] value;
        logic [15:0] raw;
        pick  = $urandom_range(99, 0);
        value = $urandom;
        raw   = 16'($urandom);
        if (pick < 35) begin
            op = OpEncSamp;
            if ($urandom_range(9, 0) != 0) begin
                enc_raw = enc_raw + 16'($urandom_range(4000, 0)) - 16'd2000;
            end else begin
                enc_raw = 16'($urandom);
            end
            raw = enc_raw;
        end else if (pick < 60) begin
            op = OpSetPos;
            case ($urandom_range(3, 0))
                0: value = track_pos + 32'(cur_pos_tol) + 32'($urandom_range(2, 0)) - 32'd1;
                1: value = track_pos - 32'(cur_pos_tol) + 32'($urandom_range(2, 0)) - 32'd1;
                2: value = track_pos + 32'($urandom_range(40, 0)) - 32'd20;
                default: value = $urandom;
            endcase
        end else if (pick < 65) begin
            op = OpZeroOfs;
        end else if (pick < 70) begin
            op = 4'($urandom_range(OpLastUnused, OpFirstUnused));
        end else begin
            op = 4'($urandom_range(OpReadEnc, OpSpeed));
        end
        send_op(op, value, raw);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Every command with reset register values, then four commands in the axis layout
    task automatic test_frame_layouts();
        send_op(OpSpeed, 32'h7FFF_FFFF, '0);
        send_op(OpSpeed, 32'h8000_0000, '1);
        send_op(OpStop, '1, '0);
        send_op(OpStopHold, '0, '0);
        send_op(OpEnable, '0, '0);
        send_op(OpDisable, '0, '0);
        send_op(OpReadEnc, '0, '0);
        send_op(OpLastUnused, '1, '1);
        drain_results();
        write_config('1, '0, '1, 31'd1000, 31'd10);
        send_op(OpSpeed, 32'h1234_5678, '0);
        send_op(OpEnable, '0, '0);
        send_op(OpReadEnc, '0, '0);
        send_op(OpDisable, '0, '0);
    endtask

    // Largest forward step, forward wrap, a step of minus half a turn, no step
    task automatic test_encoder_unwrap();
        send_op(OpEncSamp, '0, 16'hFFFF);
        send_op(OpEncSamp, '0, 16'h0000);
        send_op(OpEncSamp, '0, 16'h8000);
        send_op(OpEncSamp, '0, 16'h8000);
        send_op(OpZeroOfs, '0, '0);
    endtask

    // Dead band: inside, both extremes of the target, edge and just past it
    task automatic test_set_position();
        send_op(OpSetPos, track_pos, '0);
        send_op(OpSetPos, 32'h8000_0000, '0);
        send_op(OpSetPos, 32'h7FFF_FFFF, '0);
        send_op(OpSetPos, track_pos - 32'(cur_pos_tol), '0);
        send_op(OpSetPos, track_pos - 32'(cur_pos_tol) - 32'd1, '0);
        drain_results();
    endtask

    // Extended ids: set-position gives no frame, commands carry the ext id
    task automatic test_ext_id_mode();
        write_config('0, '1, '0, '1, '0);
        send_op(OpSetPos, 32'h7FFF_FFFF, '0);
        send_op(OpSpeed, 32'hA5A5_5A5A, '0);
        send_op(OpFirstUnused, '0, '0);
        drain_results();
    endtask

    // Random blocks, each with its own register setting; each pair of blocks shares an idle pattern
    task automatic test_random_traffic();
        for (int b = 0; b < 6; b++) begin
            case (b)
                0: write_config('0, '0, 11'($urandom), 31'($urandom_range(5000, 1)), 31'd10);
                1: write_config('1, '0, '1, '1, '0);
                2: write_config(8'($urandom_range(255, 1)), '0, '0, '0, '1);
                3: write_config('0, '1, 11'($urandom), 31'($urandom), 31'($urandom_range(500, 0)));
                4: write_config(8'd1, '0, 11'($urandom), 31'($urandom),
                                31'($urandom_range(1000, 0)));
                default: write_config(8'($urandom), '0, 11'($urandom), 31'($urandom),
                                      31'($urandom_range(100000, 0)));
            endcase
            if (b < 2) begin
                send_idle_pct = 23;
                recv_idle_pct = 70;
            end else if (b < 4) begin
                send_idle_pct = 70;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (BlockItems) send_random_item();
            drain_results();
        end
    endtask

    // Long result-side stall while operations keep coming: input must stall
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests = hold_requests + 1;
        repeat (BurstItems) send_random_item();
        drain_results();
    endtask

    initial begin
        init_model();
        send_idle_pct = 23;
        recv_idle_pct = 70;
        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_frame_layouts();
        test_encoder_unwrap();
        test_set_position();
        test_ext_id_mode();
        test_random_traffic();
        test_backpressure();

        mismatches = mismatches + due_results.size();
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
